// ----- hw/rtl/ilha_pkg.sv -----
`timescale 1ns / 1ps

package ilha_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_LAYOUT = 18'h00002,
    S_DISP   = 18'h00004,
    S_FR_CHK = 18'h00008,
    S_FF_RD  = 18'h00010,
    S_FF_CHK = 18'h00020,
    S_GROW   = 18'h00040,
    S_MG0    = 18'h00080,
    S_MG1    = 18'h00100,
    S_MG2    = 18'h00200,
    S_MG3    = 18'h00400,
    S_MG4    = 18'h00800,
    S_MG5    = 18'h01000,
    S_PL_RD  = 18'h02000,
    S_PL_CHK = 18'h04000,
    S_WRQ    = 18'h08000,
    S_MRET   = 18'h10000,
    S_FIN    = 18'h20000
  } state_e;

  // Where a heap growth returns to once its merge is done.
  typedef enum logic [1:0] {
    RET_LAY   = 2'd0,
    RET_ALLOC = 2'd1,
    RET_FREE  = 2'd2
  } ret_e;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_IGNORED = 2'd1;
  localparam logic [1:0] STATUS_NOMEM   = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [31:0] TAG_SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] TAG_PROLOGUE  = 32'h0000_0009;
  localparam logic [31:0] TAG_EPILOGUE  = 32'h0000_0001;
  localparam logic [31:0] TAG_PAD       = 32'h0000_0000;
  localparam logic [16:0] CHUNK_RESET   = 17'd4096;
  localparam int unsigned MIN_BLOCK     = 16;

  // Growth in bytes: a word count rounded up to even, never zero.
  function automatic logic [17:0] grow_size(input logic [16:0] g);
    logic [14:0] w;
    logic [15:0] we;
    w  = g[16:2];
    we = {1'b0, w} + {15'b0, w[0]};
    return (we == 16'd0) ? 18'd8 : {we, 2'b00};
  endfunction

  // Block size for a payload request: rounded to 8, plus tags, at least 16.
  function automatic logic [16:0] need_size(input logic [15:0] req);
    logic [16:0] s;
    s = {1'b0, req} + 17'd15;
    return (req <= 16'd8) ? 17'(MIN_BLOCK) : {s[16:3], 3'b000};
  endfunction

endpackage

// ----- hw/rtl/implicit_list_heap_allocator.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Signals
// ------- | --------- | ---------------------------------------------------
// in      | input     | in_valid_i, in_ready_o, mode_i, request_bytes_i,
//         |           | free_addr_i
// out     | output    | out_valid_o, out_ready_i, block_addr_o, status_o
// cfg     | input     | cfg_wr_en_i, cfg_wr_data_i (chunk_bytes)
//
// One item is handled at a time; the heap lives in one memory with a single
// write port and one registered read port, so tag accesses are made one at a
// time. An allocate walks the blocks first fit and grows the heap when none
// fits; the heap is laid out on first use. Reset clears the break, the layout
// flag and the output valid flag and sets the chunk register to 4096; the
// heap memory is not cleared.
// A result waiting on out does not block the next item from being accepted,
// but its result is held until the waiting one is taken.
module implicit_list_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [16:0] cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] free_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] block_addr_o,
  output logic [1:0]  status_o
);
  import ilha_pkg::*;

  // The heap word count must be a power of two: addresses wrap on it.
  localparam int unsigned NW = HEAP_BYTES / 4;
  localparam int unsigned AW = $clog2(NW);
  localparam int unsigned BW = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned AD = 34;

  function automatic logic [AW-1:0] widx(input logic [AD-1:0] a);
    return a[AW+1:2];
  endfunction

  function automatic logic [AD-1:0] tsz(input logic [31:0] t);
    return {{(AD-32){1'b0}}, t & TAG_SIZE_MASK};
  endfunction

  // Heap memory and its ports.
  logic [31:0]   mem_q [NW];
  logic [31:0]   rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  state_e        state_q, state_d, next_q, next_d;
  ret_e          ret_q, ret_d;
  logic          mode_q, mode_d;
  logic [15:0]   req_q, req_d, fa_q, fa_d;
  logic [16:0]   need_q, need_d, chunk_q, chunk_d;
  logic [BW-1:0] brk_q, brk_d;
  logic          ready_q, ready_d;
  logic [AD-1:0] bp_q, bp_d, mbp_q, mbp_d, mres_q, mres_d;
  logic [17:0]   gsz_q, gsz_d;
  logic [AD-1:0] msize_q, msize_d, mpsz_q, mpsz_d, mnsz_q, mnsz_d, mpvsz_q, mpvsz_d;
  logic          mpa_q, mpa_d, mna_q, mna_d;
  logic [15:0]   raddr_q, raddr_d, oaddr_q, oaddr_d;
  logic [1:0]    rstat_q, rstat_d, ostat_q, ostat_d;
  logic          ovalid_q, ovalid_d;
  logic [AW-1:0] wqi_q [4];
  logic [AW-1:0] wqi_d [4];
  logic [31:0]   wqd_q [4];
  logic [31:0]   wqd_d [4];
  logic [2:0]    wqn_q, wqn_d, wqp_q, wqp_d;

  logic [AD-1:0] brk_x, sz, s, nx, pv, rem, gsum;
  logic [16:0]   gmax;

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = ovalid_q;
  assign block_addr_o = oaddr_q;
  assign status_o     = ostat_q;

  always_comb begin
    state_d  = state_q;
    next_d   = next_q;
    ret_d    = ret_q;
    mode_d   = mode_q;
    req_d    = req_q;
    fa_d     = fa_q;
    need_d   = need_q;
    chunk_d  = cfg_wr_en_i ? cfg_wr_data_i : chunk_q;
    brk_d    = brk_q;
    ready_d  = ready_q;
    bp_d     = bp_q;
    mbp_d    = mbp_q;
    mres_d   = mres_q;
    gsz_d    = gsz_q;
    msize_d  = msize_q;
    mpsz_d   = mpsz_q;
    mnsz_d   = mnsz_q;
    mpvsz_d  = mpvsz_q;
    mpa_d    = mpa_q;
    mna_d    = mna_q;
    raddr_d  = raddr_q;
    rstat_d  = rstat_q;
    oaddr_d  = oaddr_q;
    ostat_d  = ostat_q;
    ovalid_d = ovalid_q && !out_ready_i;
    wqi_d    = wqi_q;
    wqd_d    = wqd_q;
    wqn_d    = wqn_q;
    wqp_d    = wqp_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = wqi_q[wqp_q[1:0]];
    mem_wdata = wqd_q[wqp_q[1:0]];
    mem_raddr = '0;
    brk_x = AD'(brk_q);
    sz    = tsz(rdata_q);
    s     = '0;
    nx    = mbp_q + msize_q;
    pv    = mbp_q - mpsz_q;
    rem   = sz - AD'(need_q);
    gsum  = brk_x + AD'(gsz_q);
    gmax  = (need_q > chunk_q) ? need_q : chunk_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          req_d   = request_bytes_i;
          fa_d    = free_addr_i;
          need_d  = need_size(request_bytes_i);
          raddr_d = '0;
          if (mode_i == MODE_FREE && free_addr_i == 16'd0) begin
            rstat_d = STATUS_IGNORED;
            state_d = S_FIN;
          end else if (!ready_q) begin
            state_d = S_LAYOUT;
          end else begin
            state_d = S_DISP;
          end
        end
      end
      S_LAYOUT: begin
        // Padding word, prologue header and footer, epilogue header.
        wqi_d[0] = AW'(0); wqd_d[0] = TAG_PAD;
        wqi_d[1] = AW'(1); wqd_d[1] = TAG_PROLOGUE;
        wqi_d[2] = AW'(2); wqd_d[2] = TAG_PROLOGUE;
        wqi_d[3] = AW'(3); wqd_d[3] = TAG_EPILOGUE;
        wqn_d   = 3'd4;
        wqp_d   = '0;
        brk_d   = BW'(16);
        ready_d = 1'b1;
        gsz_d   = grow_size(chunk_q);
        ret_d   = RET_LAY;
        next_d  = S_GROW;
        state_d = S_WRQ;
      end
      S_GROW: begin
        if (gsum > AD'(HEAP_BYTES)) begin
          if (ret_q == RET_ALLOC) begin
            rstat_d = STATUS_NOMEM;
            state_d = S_FIN;
          end else begin
            state_d = S_DISP;
          end
        end else begin
          // New block over the old epilogue, then a fresh epilogue.
          mbp_d    = brk_x;
          brk_d    = gsum[BW-1:0];
          wqi_d[0] = widx(brk_x - AD'(4));  wqd_d[0] = 32'(gsz_q);
          wqi_d[1] = widx(gsum - AD'(8));   wqd_d[1] = 32'(gsz_q);
          wqi_d[2] = widx(gsum - AD'(4));   wqd_d[2] = TAG_EPILOGUE;
          wqn_d    = 3'd3;
          wqp_d    = '0;
          next_d   = S_MG0;
          state_d  = S_WRQ;
        end
      end
      S_WRQ: begin
        mem_we = 1'b1;
        wqp_d  = wqp_q + 3'd1;
        if (wqp_q == wqn_q - 3'd1) begin
          state_d = next_q;
        end
      end
      S_MG0: begin
        mem_re    = 1'b1;
        mem_raddr = widx(mbp_q - AD'(4));
        state_d   = S_MG1;
      end
      S_MG1: begin
        msize_d   = sz;
        mem_re    = 1'b1;
        mem_raddr = widx(mbp_q - AD'(8));
        state_d   = S_MG2;
      end
      S_MG2: begin
        mpa_d     = rdata_q[0];
        mpsz_d    = sz;
        mem_re    = 1'b1;
        mem_raddr = widx(nx - AD'(4));
        state_d   = S_MG3;
      end
      S_MG3: begin
        mna_d     = rdata_q[0];
        mnsz_d    = sz;
        mem_re    = 1'b1;
        mem_raddr = widx(pv - AD'(4));
        state_d   = S_MG4;
      end
      S_MG4: begin
        mpvsz_d   = sz;
        mem_re    = 1'b1;
        mem_raddr = widx(nx + mnsz_q - AD'(8));
        state_d   = S_MG5;
      end
      S_MG5: begin
        wqn_d  = 3'd2;
        wqp_d  = '0;
        next_d = S_MRET;
        if (mpa_q && mna_q) begin
          mres_d  = mbp_q;
          state_d = S_MRET;
        end else if (mpa_q) begin
          s        = msize_q + mnsz_q;
          mres_d   = mbp_q;
          wqi_d[0] = widx(mbp_q - AD'(4));     wqd_d[0] = s[31:0];
          wqi_d[1] = widx(mbp_q + s - AD'(8)); wqd_d[1] = s[31:0];
          state_d  = S_WRQ;
        end else if (mna_q) begin
          s        = msize_q + mpvsz_q;
          mres_d   = pv;
          wqi_d[0] = widx(nx - AD'(8));        wqd_d[0] = s[31:0];
          wqi_d[1] = widx(pv - AD'(4));        wqd_d[1] = s[31:0];
          state_d  = S_WRQ;
        end else begin
          s        = msize_q + mpvsz_q + sz;
          mres_d   = pv;
          wqi_d[0] = widx(pv - AD'(4));               wqd_d[0] = s[31:0];
          wqi_d[1] = widx(nx + mnsz_q - AD'(8));      wqd_d[1] = s[31:0];
          state_d  = S_WRQ;
        end
      end
      S_MRET: begin
        case (ret_q)
          RET_LAY: state_d = S_DISP;
          RET_ALLOC: begin
            bp_d    = mres_q;
            state_d = S_PL_RD;
          end
          RET_FREE: begin
            rstat_d = STATUS_DONE;
            state_d = S_FIN;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_DISP: begin
        if (mode_q == MODE_ALLOC) begin
          if (req_q == 16'd0) begin
            rstat_d = STATUS_IGNORED;
            state_d = S_FIN;
          end else begin
            bp_d    = AD'(8);
            state_d = S_FF_RD;
          end
        end else if (fa_q[2:0] == 3'd0 && fa_q >= 16'd16 && AD'(fa_q) < brk_x) begin
          mem_re    = 1'b1;
          mem_raddr = widx(AD'(fa_q) - AD'(4));
          state_d   = S_FR_CHK;
        end else begin
          rstat_d = STATUS_IGNORED;
          state_d = S_FIN;
        end
      end
      S_FR_CHK: begin
        if (rdata_q[0] && sz >= AD'(8) && AD'(fa_q) + sz <= brk_x) begin
          wqi_d[0] = widx(AD'(fa_q) - AD'(4));      wqd_d[0] = sz[31:0];
          wqi_d[1] = widx(AD'(fa_q) + sz - AD'(8)); wqd_d[1] = sz[31:0];
          wqn_d    = 3'd2;
          wqp_d    = '0;
          mbp_d    = AD'(fa_q);
          ret_d    = RET_FREE;
          next_d   = S_MG0;
          state_d  = S_WRQ;
        end else begin
          rstat_d = STATUS_IGNORED;
          state_d = S_FIN;
        end
      end
      S_FF_RD: begin
        if (bp_q >= brk_x) begin
          gsz_d   = grow_size(gmax);
          ret_d   = RET_ALLOC;
          state_d = S_GROW;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = widx(bp_q - AD'(4));
          state_d   = S_FF_CHK;
        end
      end
      S_FF_CHK: begin
        if (sz == '0) begin
          gsz_d   = grow_size(gmax);
          ret_d   = RET_ALLOC;
          state_d = S_GROW;
        end else if (!rdata_q[0] && AD'(need_q) <= sz && bp_q + sz <= brk_x) begin
          state_d = S_PL_RD;
        end else begin
          bp_d    = bp_q + sz;
          state_d = S_FF_RD;
        end
      end
      S_PL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = widx(bp_q - AD'(4));
        state_d   = S_PL_CHK;
      end
      S_PL_CHK: begin
        wqp_d   = '0;
        next_d  = S_FIN;
        raddr_d = bp_q[15:0];
        rstat_d = STATUS_DONE;
        if (rem >= AD'(MIN_BLOCK)) begin
          // Split: allocated front part, free remainder behind it.
          wqi_d[0] = widx(bp_q - AD'(4));
          wqd_d[0] = 32'(need_q) | 32'd1;
          wqi_d[1] = widx(bp_q + AD'(need_q) - AD'(8));
          wqd_d[1] = 32'(need_q) | 32'd1;
          wqi_d[2] = widx(bp_q + AD'(need_q) - AD'(4));
          wqd_d[2] = rem[31:0];
          wqi_d[3] = widx(bp_q + sz - AD'(8));
          wqd_d[3] = rem[31:0];
          wqn_d    = 3'd4;
        end else begin
          wqi_d[0] = widx(bp_q - AD'(4));       wqd_d[0] = sz[31:0] | 32'd1;
          wqi_d[1] = widx(bp_q + sz - AD'(8));  wqd_d[1] = sz[31:0] | 32'd1;
          wqn_d    = 3'd2;
        end
        state_d = S_WRQ;
      end
      S_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          oaddr_d  = raddr_q;
          ostat_d  = rstat_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      next_q   <= S_IDLE;
      ret_q    <= RET_LAY;
      chunk_q  <= CHUNK_RESET;
      brk_q    <= '0;
      ready_q  <= 1'b0;
      ovalid_q <= 1'b0;
      wqn_q    <= '0;
      wqp_q    <= '0;
    end else begin
      state_q  <= state_d;
      next_q   <= next_d;
      ret_q    <= ret_d;
      chunk_q  <= chunk_d;
      brk_q    <= brk_d;
      ready_q  <= ready_d;
      ovalid_q <= ovalid_d;
      wqn_q    <= wqn_d;
      wqp_q    <= wqp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    req_q   <= req_d;
    fa_q    <= fa_d;
    need_q  <= need_d;
    bp_q    <= bp_d;
    mbp_q   <= mbp_d;
    mres_q  <= mres_d;
    gsz_q   <= gsz_d;
    msize_q <= msize_d;
    mpsz_q  <= mpsz_d;
    mnsz_q  <= mnsz_d;
    mpvsz_q <= mpvsz_d;
    mpa_q   <= mpa_d;
    mna_q   <= mna_d;
    raddr_q <= raddr_d;
    rstat_q <= rstat_d;
    oaddr_q <= oaddr_d;
    ostat_q <= ostat_d;
    wqi_q   <= wqi_d;
    wqd_q   <= wqd_d;
  end

  // The sequencer never reads and writes the heap in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_we && mem_re))
    else $error("heap read and write in the same cycle");

  // The break never passes the heap capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) AD'(brk_q) <= AD'(HEAP_BYTES))
    else $error("heap break beyond capacity");

  // Once laid out, the break covers at least the prologue and epilogue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ready_q |-> brk_q >= BW'(16))
    else $error("laid-out heap with break below 16");

  // A delivered result never carries an unknown status code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_DONE || status_o == STATUS_IGNORED ||
                     status_o == STATUS_NOMEM))
    else $error("bad status code");

endmodule
